>>> rtl/rta_pkg.sv
package rta_pkg;

    localparam int TAG_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int ID_BITS_DEF = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 2'd0,
        ST_FULL    = 2'd1,
        ST_FREED   = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic {
        REQ_RESERVE = 1'b0,
        REQ_FREE    = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        SM_FROM  = 2'd0,
        SM_ALL   = 2'd1,
        SM_BELOW = 2'd2
    } t_scan_mode;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_SCAN,
        S_FCHK,
        S_DONE
    } t_state;

    // log2 of the map word width: 64-bit words, narrower for small tag spaces
    function automatic int word_log(input int id_bits);
        int r;
        if (id_bits >= 7) begin
            r = 6;
        end else begin
            r = id_bits - 1;
        end
        return r;
    endfunction

endpackage

>>> rtl/rta_if.sv
interface rta_req_if
    import rta_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [TAG_W-1:0] tag;

    modport source (output valid, output req_type, output tag, input ready);
    modport sink   (input valid, input req_type, input tag, output ready);
endinterface

interface rta_res_if
    import rta_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag_res;

    modport source (output valid, output status, output tag_res, input ready);
    modport sink   (input valid, input status, input tag_res, output ready);
endinterface

>>> rtl/request_tag_allocator.sv
// Request tag allocator: pool of 2^ID_BITS outstanding-request tags.
// i_req (valid/ready): req_type reserve or free, tag (used on free only).
// o_res (valid/ready): status (granted, pool full, freed, unknown tag) and
// tag_res (granted tag, echoed tag on free, zero on pool full).
// The busy map sits in a single-port-read memory of 64-bit words
// (narrower words for small tag spaces); one word is scanned per cycle
// by a shared find-first-free unit, starting one past the last grant.
// The map has 2^(ID_BITS-6) words, or 2 words when ID_BITS is below 7.
// A reserve whose first scanned word holds a free tag, and a free, pass
// through S_RD, then S_SCAN or S_FCHK, then S_DONE, and the result is
// then loaded into the output register; each further word scanned adds
// one more visit to S_SCAN. A full pool visits every word plus the first
// one again. A free with a tag outside the tag space goes from S_IDLE
// straight to S_DONE. One item is in work at a time; the next transfer is
// taken in S_IDLE once the result is loaded into the output register.
// Reset: the map is cleared by a pass of one word per cycle over every
// map word, with ready low throughout.
// Stall: the result waits in an output register; the next item is taken
// and worked on, and its result waits until the register is drained.
module request_tag_allocator
    import rta_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rta_req_if.sink   i_req,
    rta_res_if.source o_res
);

    localparam int WORD_LOG  = word_log(ID_BITS);
    localparam int WORD_BITS = 1 << WORD_LOG;
    localparam int ADDR_BITS = ID_BITS - WORD_LOG;
    localparam int CNT_W     = ADDR_BITS + 1;
    localparam int WORDS     = 1 << ADDR_BITS;
    localparam logic [TAG_W:0] TAG_COUNT = (TAG_W+1)'(1) << ID_BITS;

    t_state                r_state, n_state;
    logic [ADDR_BITS-1:0]  r_addr, n_addr;
    logic [WORD_LOG-1:0]   r_off, n_off;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [ID_BITS-1:0]    r_last, n_last;
    logic                  r_is_free, n_is_free;
    logic [TAG_W-1:0]      r_tag, n_tag;
    t_status               r_status, n_status;
    logic [TAG_W-1:0]      r_res_tag, n_res_tag;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [TAG_W-1:0]      r_out_tag, n_out_tag;

    logic                  w_we;
    logic [ADDR_BITS-1:0]  w_waddr;
    logic [WORD_BITS-1:0]  w_wdata;
    logic                  w_re;
    logic [ADDR_BITS-1:0]  w_raddr;
    logic [WORD_BITS-1:0]  w_rdata;
    t_scan_mode            w_mode;
    logic                  w_found;
    logic [WORD_LOG-1:0]   w_idx;
    logic [ID_BITS-1:0]    w_start;
    logic                  w_in_range;

    rta_map #(
        .ADDR_BITS (ADDR_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rta_scan #(
        .WORD_LOG (WORD_LOG)
    ) u_scan (
        .i_word  (w_rdata),
        .i_off   (r_off),
        .i_mode  (w_mode),
        .o_found (w_found),
        .o_idx   (w_idx)
    );

    assign w_start    = ID_BITS'(r_last + 1'b1);
    assign w_in_range = ({1'b0, i_req.tag} < TAG_COUNT);

    // first visit skips bits below the start, the wrap visit takes only those
    always_comb begin
        if (r_cnt == '0) begin
            w_mode = SM_FROM;
        end else if (r_cnt == CNT_W'(WORDS)) begin
            w_mode = SM_BELOW;
        end else begin
            w_mode = SM_ALL;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_off        = r_off;
        n_cnt        = r_cnt;
        n_last       = r_last;
        n_is_free    = r_is_free;
        n_tag        = r_tag;
        n_status     = r_status;
        n_res_tag    = r_res_tag;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_tag    = r_out_tag;
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = '0;
        w_re         = 1'b0;
        w_raddr      = r_addr;
        i_req.ready  = 1'b0;

        case (r_state)
            S_CLEAR: begin
                w_we   = 1'b1;
                n_addr = ADDR_BITS'(r_addr + 1'b1);
                if (r_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_tag = i_req.tag;
                    if (i_req.req_type == REQ_RESERVE) begin
                        n_is_free = 1'b0;
                        n_addr    = w_start[ID_BITS-1:WORD_LOG];
                        n_off     = w_start[WORD_LOG-1:0];
                        n_cnt     = '0;
                        n_state   = S_RD;
                    end else if (w_in_range) begin
                        n_is_free = 1'b1;
                        n_addr    = i_req.tag[ID_BITS-1:WORD_LOG];
                        n_off     = i_req.tag[WORD_LOG-1:0];
                        n_state   = S_RD;
                    end else begin
                        n_is_free = 1'b1;
                        n_status  = ST_UNKNOWN;
                        n_res_tag = i_req.tag;
                        n_state   = S_DONE;
                    end
                end
            end
            S_RD: begin
                w_re    = 1'b1;
                n_state = r_is_free ? S_FCHK : S_SCAN;
            end
            S_SCAN: begin
                if (w_found) begin
                    w_we      = 1'b1;
                    w_wdata   = w_rdata | (WORD_BITS'(1) << w_idx);
                    n_last    = {r_addr, w_idx};
                    n_status  = ST_GRANTED;
                    n_res_tag = TAG_W'({r_addr, w_idx});
                    n_state   = S_DONE;
                end else if (r_cnt == CNT_W'(WORDS)) begin
                    n_status  = ST_FULL;
                    n_res_tag = '0;
                    n_state   = S_DONE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = ADDR_BITS'(r_addr + 1'b1);
                    n_addr  = ADDR_BITS'(r_addr + 1'b1);
                    n_cnt   = CNT_W'(r_cnt + 1'b1);
                end
            end
            S_FCHK: begin
                n_res_tag = r_tag;
                if (w_rdata[r_off]) begin
                    w_we     = 1'b1;
                    w_wdata  = w_rdata & ~(WORD_BITS'(1) << r_off);
                    n_status = ST_FREED;
                end else begin
                    n_status = ST_UNKNOWN;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_tag    = r_res_tag;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_cnt       <= '0;
            r_last      <= '0;
            r_is_free   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_is_free   <= n_is_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off        <= n_off;
        r_tag        <= n_tag;
        r_status     <= n_status;
        r_res_tag    <= n_res_tag;
        r_out_status <= n_out_status;
        r_out_tag    <= n_out_tag;
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.status  = r_out_status;
    assign o_res.tag_res = r_out_tag;

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR && r_addr == '0))
        else $error("clearing pass not restarted by reset");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= CNT_W'(WORDS)))
        else $error("scan ran past the wrap visit");

    a_grant_free_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_found) |-> !w_rdata[w_idx])
        else $error("grant of a busy tag");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("transfer accepted but no work started");

endmodule

>>> rtl/rta_scan.sv
module rta_scan
    import rta_pkg::*;
#(
    parameter int WORD_LOG = 6
) (
    input  logic [(1<<WORD_LOG)-1:0] i_word,
    input  logic [WORD_LOG-1:0]      i_off,
    input  t_scan_mode               i_mode,
    output logic                     o_found,
    output logic [WORD_LOG-1:0]      o_idx
);

    localparam int WORD_BITS = 1 << WORD_LOG;

    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_cand;

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            case (i_mode)
                SM_FROM:  w_mask[i] = (WORD_LOG'(i) >= i_off);
                SM_BELOW: w_mask[i] = (WORD_LOG'(i) < i_off);
                SM_ALL:   w_mask[i] = 1'b1;
                default:  w_mask[i] = 1'b0;
            endcase
        end
    end

    assign w_cand  = ~i_word & w_mask;
    assign o_found = |w_cand;

    // lowest free bit
    always_comb begin
        o_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w_cand[i]) begin
                o_idx = WORD_LOG'(i);
            end
        end
    end

endmodule

>>> rtl/rta_map.sv
module rta_map
    import rta_pkg::*;
#(
    parameter int ADDR_BITS = 10,
    parameter int WORD_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WORD_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [(1<<ADDR_BITS)];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/request_tag_allocator_tb.sv
`timescale 1ns / 100ps

module request_tag_allocator_tb
    import rta_pkg::*;
;

    localparam int TB_ID_BITS   = ID_BITS_DEF;
    localparam int TAG_SPACE    = 1 << TB_ID_BITS;
    localparam int CLK_PERIOD   = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        t_status          status;
        logic [TAG_W-1:0] tag;
    } t_tag_result;

    logic i_clk;
    logic i_rst_n;

    rta_req_if req_if ();
    rta_res_if res_if ();

    request_tag_allocator #(
        .ID_BITS (TB_ID_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    logic        tag_busy [TAG_SPACE];
    int          busy_count;
    int          last_grant;
    t_tag_result pending_results [$];

    int src_idle_pct;
    int sink_stall_pct;
    int sink_hold_cycles;
    int fail_count;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // result-side ready, with an optional long hold-off
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                sink_hold_cycles--;
            end else begin
                res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // result checker
    initial begin
        t_tag_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result status %0d tag %0d", $time,
                             res_if.status, res_if.tag_res);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (t_status'(res_if.status) != want.status) begin
                        $display("%0t: status mismatch expected %0d actual %0d", $time,
                                 want.status, res_if.status);
                        fail_count++;
                    end
                    if (res_if.tag_res != want.tag) begin
                        $display("%0t: tag mismatch expected %0d actual %0d", $time,
                                 want.tag, res_if.tag_res);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic predict_tag_result(input t_req_type kind, input logic [TAG_W-1:0] tag);
        t_tag_result r;
        int          cand;
        int          tries;
        r.status = ST_FULL;
        r.tag    = '0;
        if (kind == REQ_RESERVE) begin
            cand  = last_grant;
            tries = 0;
            while (tries < TAG_SPACE && r.status == ST_FULL) begin
                cand = (cand + 1) % TAG_SPACE;
                if (!tag_busy[cand]) begin
                    tag_busy[cand] = 1'b1;
                    busy_count++;
                    last_grant = cand;
                    r.status   = ST_GRANTED;
                    r.tag      = cand[TAG_W-1:0];
                end
                tries++;
            end
        end else begin
            r.tag = tag;
            if (tag < TAG_SPACE && tag_busy[tag]) begin
                tag_busy[tag] = 1'b0;
                busy_count--;
                r.status = ST_FREED;
            end else begin
                r.status = ST_UNKNOWN;
            end
        end
        pending_results.push_back(r);
    endtask

    // valid is left high after a transfer; it drops only in a gap
    task automatic send_request(input t_req_type kind, input logic [TAG_W-1:0] tag);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.tag      <= tag;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_tag_result(kind, tag);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // first busy tag at or after the seed, or the seed itself when none is busy
    function automatic logic [TAG_W-1:0] busy_tag_from(input logic [TAG_W-1:0] seed);
        logic [TAG_W-1:0] t;
        int               idx;
        bit               hit;
        t   = seed;
        hit = 1'b0;
        for (int n = 0; n < TAG_SPACE && busy_count > 0 && !hit; n++) begin
            idx = (seed + n) % TAG_SPACE;
            if (tag_busy[idx]) begin
                t   = idx[TAG_W-1:0];
                hit = 1'b1;
            end
        end
        return t;
    endfunction

    task automatic send_random_item(input int reserve_pct);
        logic [TAG_W-1:0] t;
        int               pick;
        t = TAG_W'($urandom);
        if ($urandom_range(99) < reserve_pct) begin
            send_request(REQ_RESERVE, t);
        end else begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                t = busy_tag_from(TAG_W'($urandom_range(last_grant)));
            end else if (pick < 85) begin
                t = TAG_W'($urandom_range(TAG_SPACE - 1));
            end
            send_request(REQ_FREE, t);
        end
    endtask

    task automatic test_directed_cases();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_request(REQ_RESERVE, 16'hffff);
        send_request(REQ_RESERVE, 16'h0000);
        send_request(REQ_FREE, 16'd1);
        send_request(REQ_FREE, 16'd1);          // already idle
        send_request(REQ_FREE, 16'd0);
        send_request(REQ_FREE, TAG_W'(TAG_SPACE - 1));
        send_request(REQ_FREE, 16'hffff);
        send_request(REQ_RESERVE, 16'h5a5a);
        send_request(REQ_FREE, 16'd2);
        send_request(REQ_FREE, 16'd3);
        wait_drained();
    endtask

    // grants run across several map words
    task automatic test_word_crossing();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        while (busy_count < 130) send_request(REQ_RESERVE, TAG_W'($urandom));
        send_request(REQ_FREE, 16'd63);
        send_request(REQ_FREE, 16'd64);         // first tag of the second map word
        send_request(REQ_FREE, 16'd128);
        send_request(REQ_FREE, 16'd127);
        repeat (4) send_request(REQ_RESERVE, TAG_W'($urandom));
        wait_drained();
    endtask

    task automatic test_hold_off();
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        sink_hold_cycles = 300;
        for (int n = 0; n < 16; n++) send_random_item(40);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int bursts);
        int reserve_pct;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int b = 0; b < bursts; b++) begin
            case ($urandom_range(2))
                0: begin
                    reserve_pct = 10;
                end
                1: begin
                    reserve_pct = 50;
                end
                default: begin
                    reserve_pct = 90;
                end
            endcase
            for (int n = 0; n < 50; n++) begin
                send_random_item(reserve_pct);
                if ($urandom_range(49) == 0) wait_drained();
            end
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_RESERVE;
        req_if.tag       = '0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        sink_hold_cycles = 0;
        fail_count       = 0;
        cycle_count      = 0;
        busy_count       = 0;
        last_grant       = 0;
        for (int n = 0; n < TAG_SPACE; n++) tag_busy[n] = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_word_crossing();
        test_hold_off();
        test_random_traffic(0, 0, 3);
        test_random_traffic(60, 0, 3);
        test_random_traffic(0, 60, 3);
        test_random_traffic(7, 7, 3);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rta_pkg.sv
rtl/rta_if.sv
rtl/rta_scan.sv
rtl/rta_map.sv
rtl/request_tag_allocator.sv
tb/request_tag_allocator_tb.sv
